@@ hdl/rdc_pkg.sv @@
// Package for the radix digit converter.
// Shared widths, status codes and the divider status bundle. No dependencies.
package rdc_pkg;

   localparam int VALUE_WIDTH_DEF = 31;
   localparam int STACK_DEPTH_DEF = 32;

   localparam int RADIX_W     = 6;
   localparam int DIGIT_W     = 6;
   localparam int STATUS_W    = 2;
   localparam int RSP_DATA_W  = 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_ZERO      = 2'd1;
   localparam status_type STATUS_BAD_RADIX = 2'd2;

   // divider -> sequencer
   typedef struct packed {
      logic               digit_valid;  // remainder of one division is ready
      logic               final_digit;  // quotient of that division is zero
      logic [DIGIT_W-1:0] remainder;
   } div_status_type;

endpackage

@@ hdl/rdc_ram.sv @@
// Generic single-port-write / single-port-read RAM, registered read.
// No dependencies.
module rdc_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rdc_divider.sv @@
// Bit-serial restoring divider: value / radix, one quotient bit per cycle.
// Repeats on its own quotient until it reaches zero. Depends on rdc_pkg.
module rdc_divider #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [VALUE_WIDTH-1:0]      load_value,
   input  logic [rdc_pkg::RADIX_W-1:0] load_radix,
   output rdc_pkg::div_status_type     status
);
   import rdc_pkg::*;

   localparam int CntW = $clog2(VALUE_WIDTH);

   logic                   run_ff, run_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [RADIX_W-1:0]     rad_ff, rad_in;
   logic [DIGIT_W-1:0]     rem_ff, rem_in;
   logic                   qnz_ff, qnz_in;

   logic [DIGIT_W:0]       trial;
   logic [DIGIT_W:0]       diff;
   logic                   take;
   logic [DIGIT_W-1:0]     rem_step;
   logic                   qnz_step;
   logic                   last_step;

   // partial remainder stays below radix (<= 35), so 7 bits cover the shifted trial
   assign trial     = {rem_ff, val_ff[VALUE_WIDTH-1]};
   assign take      = trial >= {1'b0, rad_ff};
   assign diff      = trial - {1'b0, rad_ff};
   assign rem_step  = take ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
   assign qnz_step  = qnz_ff | take;
   assign last_step = run_ff && (cnt_ff == CntW'(VALUE_WIDTH - 1));

   assign status.digit_valid = last_step;
   assign status.final_digit = last_step && !qnz_step;
   assign status.remainder   = rem_step;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      val_in = val_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      qnz_in = qnz_ff;
      if (load) begin
         run_in = 1'b1;
         cnt_in = '0;
         val_in = load_value;
         rad_in = load_radix;
         rem_in = '0;
         qnz_in = 1'b0;
      end else if (run_ff) begin
         // quotient bits shift in from the bottom as dividend bits leave the top
         val_in = {val_ff[VALUE_WIDTH-2:0], take};
         if (last_step) begin
            cnt_in = '0;
            rem_in = '0;
            qnz_in = 1'b0;
            run_in = qnz_step;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            rem_in = rem_step;
            qnz_in = qnz_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      val_ff <= val_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      qnz_ff <= qnz_in;
   end

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (rem_ff < rad_ff))
      else $error("divider remainder not below radix");

   a_load_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      load |=> (run_ff && cnt_ff == '0))
      else $error("divider did not restart on load");

   a_cnt_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(VALUE_WIDTH - 1))
      else $error("divider bit count beyond value width");

endmodule

@@ hdl/radix_digit_converter_unit.sv @@
// Radix digit converter top level: digit sequencer, digit stack, output register.
// Depends on rdc_pkg, rdc_divider and rdc_ram.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  req      | in  | req_tvalid/tready    | tdata: value, radix
//  rsp      | out | rsp_tvalid/tready    | tdata: digit; tuser: status; tlast: last
//
// Each digit comes from a pass of the bit-serial divider (one quotient bit per cycle);
//   then digits are popped from the stack: state POP issues the registered RAM read,
//   state LOAD fills the output register. Bad radix or zero value skips the divider.
// One item is worked at a time; a new transaction is taken once the stack is empty
//   and the output register is free or draining.
// Reset is synchronous, active high; the digit stack RAM itself is not cleared.
// rsp stalls hold the output register and pause the pop sequence.
module radix_digit_converter_unit #(
   parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
   parameter int STACK_DEPTH = rdc_pkg::STACK_DEPTH_DEF,
   localparam int REQ_DATA_W = ((VALUE_WIDTH + rdc_pkg::RADIX_W + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // req: value [VALUE_WIDTH-1:0], radix [VALUE_WIDTH+5:VALUE_WIDTH], zero fill
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_DATA_W-1:0]          req_tdata,
   // rsp: digit [5:0], zero fill [7:6]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rdc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [rdc_pkg::STATUS_W-1:0]   rsp_tuser,
   output logic                           rsp_tlast
);
   import rdc_pkg::*;

   localparam int AddrW  = $clog2(STACK_DEPTH);
   localparam int CountW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_POP  = 4'b0100,
      ST_LOAD = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CountW-1:0]  count_ff, count_in;     // entries on the digit stack
   logic [CountW-1:0]  count_dec;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic               last_ff, last_in;
   status_type         status_ff, status_in;

   logic [VALUE_WIDTH-1:0] req_value;
   logic [RADIX_W-1:0]     req_radix;
   logic                   req_fire;
   logic                   out_free;
   logic                   bad_radix;
   logic                   zero_value;

   div_status_type     div_st;
   logic               div_load;

   logic               ram_we, ram_re;
   logic [DIGIT_W-1:0] ram_rd_data;

   assign req_value  = req_tdata[VALUE_WIDTH-1:0];
   assign req_radix  = req_tdata[VALUE_WIDTH +: RADIX_W];
   assign bad_radix  = (req_radix < RADIX_MIN) || (req_radix > RADIX_MAX);
   assign zero_value = (req_value == '0);

   // output register is free now or is emptied this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign div_load   = req_fire && !bad_radix && !zero_value;
   assign count_dec  = count_ff - 1'b1;

   // push each remainder; digits beyond the stack depth (most significant) are dropped
   assign ram_we = (state_ff == ST_DIV) && div_st.digit_valid &&
                   (count_ff < CountW'(STACK_DEPTH));
   assign ram_re = (state_ff == ST_POP) && out_free;

   rdc_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .load       (div_load),
      .load_value (req_value),
      .load_radix (req_radix),
      .status     (div_st)
   );

   rdc_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[AddrW-1:0]),
      .wr_data (div_st.remainder),
      .rd_en   (ram_re),
      .rd_addr (count_dec[AddrW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      digit_in     = digit_ff;
      last_in      = last_ff;
      status_in    = status_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               count_in = '0;
               if (bad_radix) begin
                  rsp_valid_in = 1'b1;
                  digit_in     = '0;
                  last_in      = 1'b1;
                  status_in    = STATUS_BAD_RADIX;
               end else if (zero_value) begin
                  rsp_valid_in = 1'b1;
                  digit_in     = '0;
                  last_in      = 1'b1;
                  status_in    = STATUS_ZERO;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (ram_we) begin
               count_in = count_ff + 1'b1;
            end
            if (div_st.final_digit) begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (ram_re) begin
               count_in = count_dec;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // read data is back; output register was freed when the read issued
            rsp_valid_in = 1'b1;
            digit_in     = ram_rd_data;
            last_in      = (count_ff == '0);
            status_in    = STATUS_OK;
            state_in     = (count_ff == '0) ? ST_IDLE : ST_POP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digit_ff  <= digit_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DIGIT_W){1'b0}}, digit_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(STACK_DEPTH))
      else $error("digit stack count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (count_ff != '0))
      else $error("pop from empty digit stack");

   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !rsp_valid_ff)
      else $error("output register occupied when popped digit arrives");

   a_no_push_and_pop: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("stack push and pop in the same cycle");

   a_divider_quiet_outside_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DIV) |-> !div_st.digit_valid)
      else $error("divider produced a digit outside the divide phase");

endmodule
